### design/u8d_pkg.sv
// Shared types, constants and decode functions for the UTF-8 stream decoder
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 3;

  localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;

  // commands from controller to datapath
  typedef struct packed {
    logic load_norm;   // decode the incoming beat as a complete sequence
    logic store;       // hold the incoming beat in the pending buffer
    logic flush_step;  // emit one result from the pending buffer
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic complete;    // held bytes plus the incoming beat cover the lead
    logic eos;         // incoming beat closes the string
    logic flush_last;  // current flush step drains the buffer
  } stat_t;

  // one decoded code point and the bytes it used
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
  } dec_t;

  // sequence length called for by a lead byte, ascii and stray bytes give one
  function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] c);
    logic [LEN_W-1:0] r;
    r = 3'd1;
    priority if (c < 8'h80)               r = 3'd1;
    else if ((c & 8'hE0) == 8'hC0)        r = 3'd2;
    else if ((c & 8'hF0) == 8'hE0)        r = 3'd3;
    else if ((c & 8'hF8) == 8'hF0)        r = 3'd4;
    else                                  r = 3'd1;
    return r;
  endfunction

  // decode one code point from b0 onward with n valid bytes
  function automatic dec_t decode(input logic [BYTE_W-1:0] b0,
                                  input logic [BYTE_W-1:0] b1,
                                  input logic [BYTE_W-1:0] b2,
                                  input logic [BYTE_W-1:0] b3,
                                  input logic [LEN_W-1:0]  n);
    dec_t             d;
    logic [LEN_W-1:0] need;
    need  = lead_len(b0);
    d.cp  = CP_REPL;
    d.len = 3'd1;
    priority if (b0 < 8'h80) begin
      d.cp  = {13'd0, b0};
      d.len = 3'd1;
    end else if (need == 3'd2 && n >= 3'd2) begin
      d.cp  = {10'd0, b0[4:0], b1[5:0]};
      d.len = 3'd2;
    end else if (need == 3'd3 && n >= 3'd3) begin
      d.cp  = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      d.len = 3'd3;
    end else if (need == 3'd4 && n >= 3'd4) begin
      d.cp  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      d.len = 3'd4;
    end else begin
      d.cp  = CP_REPL;
      d.len = 3'd1;
    end
    return d;
  endfunction

endpackage

### design/u8d_datapath.sv
// Pending byte buffer, decoders and output register of the UTF-8 decoder
`timescale 1ns / 1ps

module u8d_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [u8d_pkg::BYTE_W-1:0] data_byte,
  input  logic                       end_of_string,
  input  u8d_pkg::cmd_t              cmd,
  output u8d_pkg::stat_t             st,
  output logic [u8d_pkg::CP_W-1:0]   code_point,
  output logic                       last_of_run
);

  logic [u8d_pkg::BYTE_W-1:0] buf_r [3];
  logic [u8d_pkg::BYTE_W-1:0] buf_nxt [3];
  logic [1:0]                 cnt_r, cnt_nxt;
  logic [u8d_pkg::CP_W-1:0]   cp_r, cp_nxt;
  logic                       last_r, last_nxt;

  logic [u8d_pkg::BYTE_W-1:0] comb0, comb1, comb2;
  logic [u8d_pkg::LEN_W-1:0]  n_comb;
  logic [1:0]                 rem;
  u8d_pkg::dec_t              dec_comb, dec_flush;

  // held bytes with the incoming beat placed right after them
  always_comb begin
    comb0  = (cnt_r == 2'd0) ? data_byte : buf_r[0];
    comb1  = (cnt_r == 2'd1) ? data_byte : buf_r[1];
    comb2  = (cnt_r == 2'd2) ? data_byte : buf_r[2];
    n_comb = {1'b0, cnt_r} + 3'd1;
  end

  assign dec_comb  = u8d_pkg::decode(comb0, comb1, comb2, data_byte, n_comb);
  assign dec_flush = u8d_pkg::decode(buf_r[0], buf_r[1], buf_r[2], 8'd0, {1'b0, cnt_r});
  assign rem       = cnt_r - dec_flush.len[1:0];

  // status for the controller
  always_comb begin
    st.complete   = (n_comb >= u8d_pkg::lead_len(comb0));
    st.eos        = end_of_string;
    st.flush_last = (rem == 2'd0);
  end

  // next buffer, count and output register
  always_comb begin
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    cp_nxt   = cp_r;
    last_nxt = last_r;
    priority if (cmd.load_norm) begin
      cp_nxt   = dec_comb.cp;
      last_nxt = 1'b1;
      cnt_nxt  = 2'd0;
    end else if (cmd.store) begin
      buf_nxt[0] = comb0;
      buf_nxt[1] = comb1;
      buf_nxt[2] = comb2;
      cnt_nxt    = n_comb[1:0];
    end else if (cmd.flush_step) begin
      cp_nxt   = dec_flush.cp;
      last_nxt = (rem == 2'd0);
      cnt_nxt  = rem;
      // drop the consumed bytes from the front
      unique case (dec_flush.len[1:0])
        2'd1: begin
          buf_nxt[0] = buf_r[1];
          buf_nxt[1] = buf_r[2];
          buf_nxt[2] = 8'd0;
        end
        2'd2: begin
          buf_nxt[0] = buf_r[2];
          buf_nxt[1] = 8'd0;
          buf_nxt[2] = 8'd0;
        end
        default: begin
          buf_nxt[0] = 8'd0;
          buf_nxt[1] = 8'd0;
          buf_nxt[2] = 8'd0;
        end
      endcase
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // count is control, bytes and result are payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    buf_r  <= buf_nxt;
    cp_r   <= cp_nxt;
    last_r <= last_nxt;
  end

  assign code_point  = cp_r;
  assign last_of_run = last_r;

  // a beat that gets held never fills past three bytes
  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> (cnt_r != 2'd3))
    else $error("store with a full pending buffer");

  // a flush step never consumes more than is held
  a_flush_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_step |-> ({1'b0, cnt_r} >= dec_flush.len && cnt_r != 2'd0))
    else $error("flush step past the held bytes");

  // a complete beat leaves nothing pending
  a_norm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_norm |=> (cnt_r == 2'd0))
    else $error("pending count not cleared after a complete sequence");

endmodule

### design/u8d_ctrl.sv
// Controller state machine and output valid of the UTF-8 decoder
`timescale 1ns / 1ps

module u8d_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  u8d_pkg::stat_t st,
  output u8d_pkg::cmd_t  cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, acc;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;

  // command decode and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (st.complete) begin
            cmd.load_norm = 1'b1;
          end else begin
            cmd.store = 1'b1;
            if (st.eos) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end
      default: begin
        if (out_free) begin
          cmd.flush_step = 1'b1;
          if (st.flush_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
    endcase
  end

  // output valid follows loads and drains on tready
  always_comb begin
    if (cmd.load_norm || cmd.flush_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // no input beat is taken while a flush is draining
  a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> !in_tready)
    else $error("input accepted during flush");

  // a held byte with no string end gives no result and stays idle
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !st.complete && !st.eos) |=> (state_r == ST_IDLE))
    else $error("hold left idle state");

  // a complete beat puts a result on the output next cycle
  a_norm_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && st.complete) |=> out_valid_r)
    else $error("complete sequence gave no result");

  // only one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_norm, cmd.store, cmd.flush_step}))
    else $error("conflicting datapath commands");

endmodule

### design/utf8_stream_decoder_unit.sv
// Top level of the streaming UTF-8 to code point decoder
`timescale 1ns / 1ps

// Takes one UTF-8 byte per beat (in_tlast marks the final byte of a string) and
// emits 21-bit code points. A lead byte opens a 1 to 4 byte sequence; following
// bytes are taken without checking continuation markers or overlong forms, and
// a stray byte gives U+FFFD. The result for the byte that completes a sequence
// is registered and shows up in the next cycle, so the sustained rate is one
// byte per clock while out_tready stays high and no flush is draining. When a
// string ends inside a sequence the lead gives U+FFFD and the held bytes are
// decoded again, one result per cycle while out_tready stays high; input is not
// accepted while that flush drains the pending buffer.
// out_tlast is high on the last result caused by an input byte.
module utf8_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic        out_tlast   // last_of_run
);

  u8d_pkg::cmd_t            cmd;
  u8d_pkg::stat_t           st;
  logic [u8d_pkg::CP_W-1:0] code_point;

  u8d_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  u8d_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .data_byte     (in_tdata),
    .end_of_string (in_tlast),
    .cmd           (cmd),
    .st            (st),
    .code_point    (code_point),
    .last_of_run   (out_tlast)
  );

  assign out_tdata = {3'd0, code_point};

endmodule
